// ===== rtl/lvm_pkg.sv =====
`timescale 1ns / 1ps
package lvm_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   typedef logic [1:0] col_idx_type;

   localparam col_idx_type COL_LAST = 2'd3;

endpackage

// ===== rtl/lvm_front.sv =====
`timescale 1ns / 1ps
module lvm_front #(
   parameter int W = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic signed [W-1:0] eye [3],
   input  logic signed [W-1:0] tgt [3],
   input  logic signed [W-1:0] up [3],
   output logic                out_valid,
   input  logic                out_ready,
   output logic signed [W-1:0] out_eye [3],
   output logic signed [W:0]   out_dir [3],
   output logic signed [W-1:0] out_up [3]
);
   import lvm_pkg::*;

   logic signed [W-1:0] eye_ff [2][3];
   logic signed [W:0]   dir_ff [2][3];
   logic signed [W-1:0] up_ff [2][3];
   logic                wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full      = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign do_push   = push && !full;
   assign do_pop    = out_valid && out_ready;

   always_comb begin
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // classify at the door: keep the eye, the view direction and the up hint
   always_ff @(posedge clock) begin
      if (do_push) begin
         for (int i = 0; i < 3; i++) begin
            eye_ff[wr_ff][i] <= eye[i];
            dir_ff[wr_ff][i] <= (W+1)'(eye[i]) - (W+1)'(tgt[i]);
            up_ff[wr_ff][i]  <= up[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_eye[i] = eye_ff[rd_ff][i];
         out_dir[i] = dir_ff[rd_ff][i];
         out_up[i]  = up_ff[rd_ff][i];
      end
   end

endmodule

// ===== rtl/lvm_core.sv =====
`timescale 1ns / 1ps
module lvm_core #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic signed [W-1:0] in_eye [3],
   input  logic signed [W:0]   in_dir [3],
   input  logic signed [W-1:0] in_up [3],
   output logic                out_valid,
   input  logic                out_ready,
   output logic signed [F+2:0] out_rgt [3],
   output logic signed [F+2:0] out_tu [3],
   output logic signed [F+2:0] out_fwd [3],
   output logic signed [W-1:0] out_trans [3]
);
   import lvm_pkg::*;

   localparam int FW   = (W + 1 > F + 33) ? W + 1 : F + 33;
   localparam int MA   = (W > 32) ? W : 32;
   localparam int MB   = (F + 3 > 32) ? F + 3 : 32;
   localparam int PW   = MA + MB;
   localparam int ACCW = PW + 2;
   localparam int QW   = F + 1;
   localparam int NW   = F + 32;
   localparam int DCW  = $clog2(QW + 1);

   localparam logic signed [ACCW-1:0] HALF = ACCW'(1) <<< (F - 1);
   localparam logic signed [ACCW-1:0] MAXV = (ACCW'(1) <<< (W - 1)) - ACCW'(1);
   localparam logic signed [ACCW-1:0] MINV = -MAXV - ACCW'(1);

   typedef enum logic [2:0] {
      S_IDLE, S_FIT, S_MUL, S_ACC, S_SQRT, S_DIVI, S_DIV, S_DONE
   } state_type;
   typedef enum logic [1:0] {P_UP, P_FWD, P_RGT} phase_type;
   typedef enum logic [1:0] {M_SQ, M_CR1, M_CR2, M_DOT} mode_type;

   state_type           state_ff, state_in;
   phase_type           ph_ff, ph_in;
   mode_type            md_ff, md_in;
   logic [1:0]          k_ff, k_in, j_ff, j_in;
   logic [FW-1:0]       v_ff [3];
   logic [FW-1:0]       v_in [3];
   logic                sgn_ff [3];
   logic                sgn_in [3];
   logic signed [W-1:0] eye_ff [3];
   logic signed [W-1:0] eye_in [3];
   logic signed [W:0]   dir_ff [3];
   logic signed [W:0]   dir_in [3];
   logic signed [31:0]  upf_ff [3];
   logic signed [31:0]  upf_in [3];
   logic signed [F+2:0] fwd_ff [3];
   logic signed [F+2:0] fwd_in [3];
   logic signed [F+2:0] rgt_ff [3];
   logic signed [F+2:0] rgt_in [3];
   logic signed [F+2:0] tu_ff [3];
   logic signed [F+2:0] tu_in [3];
   logic signed [W-1:0] tr_ff [3];
   logic signed [W-1:0] tr_in [3];
   logic signed [PW-1:0]   prod_ff, prod_in;
   logic signed [ACCW-1:0] acc_ff, acc_in;
   logic [63:0]         s_ff, s_in, r_ff, r_in, bit_ff, bit_in;
   logic [4:0]          sc_ff, sc_in;
   logic [31:0]         len_ff, len_in, rem_ff, rem_in;
   logic [QW-1:0]       nsh_ff, nsh_in, q_ff, q_in;
   logic [DCW-1:0]      dc_ff, dc_in;
   logic signed [MA-1:0] opa;
   logic signed [MB-1:0] opb;

   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_DONE);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_rgt[i]   = rgt_ff[i];
         out_tu[i]    = tu_ff[i];
         out_fwd[i]   = fwd_ff[i];
         out_trans[i] = tr_ff[i];
      end
   end

   // shared multiplier operand select
   always_comb begin
      logic [1:0] i1, i2, ia, ib;
      logic signed [F+2:0] axis;
      i1 = (k_ff == 2'd2) ? 2'd0 : k_ff + 2'd1;
      i2 = (k_ff == 2'd0) ? 2'd2 : k_ff - 2'd1;
      ia = (j_ff == 2'd0) ? i1 : i2;
      ib = (j_ff == 2'd0) ? i2 : i1;
      case (k_ff)
         2'd0:    axis = rgt_ff[j_ff];
         2'd1:    axis = tu_ff[j_ff];
         default: axis = fwd_ff[j_ff];
      endcase
      case (md_ff)
         M_SQ: begin
            opa = $signed({{(MA-31){1'b0}}, v_ff[k_ff][30:0]});
            opb = $signed({{(MB-31){1'b0}}, v_ff[k_ff][30:0]});
         end
         M_CR1: begin
            opa = MA'(upf_ff[ia]);
            opb = MB'(fwd_ff[ib]);
         end
         M_CR2: begin
            opa = MA'(fwd_ff[ia]);
            opb = MB'(rgt_ff[ib]);
         end
         default: begin
            opa = MA'(eye_ff[j_ff]);
            opb = MB'(axis);
         end
      endcase
   end

   always_comb begin
      logic [FW-1:0]          orv;
      logic [64:0]            sq_t;
      logic                   sq_ge;
      logic [32:0]            rem2;
      logic                   dv_ge;
      logic [NW-1:0]          num;
      logic signed [ACCW-1:0] addend, amag, rq, fl;
      logic signed [F+2:0]    qs;
      logic signed [W:0]      mu;
      logic signed [W+1:0]    mdr;
      logic signed [31:0]     t32;
      logic                   norm_done, vz;

      state_in = state_ff;
      ph_in    = ph_ff;
      md_in    = md_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      v_in     = v_ff;
      sgn_in   = sgn_ff;
      eye_in   = eye_ff;
      dir_in   = dir_ff;
      upf_in   = upf_ff;
      fwd_in   = fwd_ff;
      rgt_in   = rgt_ff;
      tu_in    = tu_ff;
      tr_in    = tr_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      s_in     = s_ff;
      r_in     = r_ff;
      bit_in   = bit_ff;
      sc_in    = sc_ff;
      len_in   = len_ff;
      rem_in   = rem_ff;
      nsh_in   = nsh_ff;
      q_in     = q_ff;
      dc_in    = dc_ff;
      norm_done = 1'b0;

      orv   = v_ff[0] | v_ff[1] | v_ff[2];
      vz    = (orv == '0);
      sq_t  = {1'b0, r_ff} + {1'b0, bit_ff};
      sq_ge = ({1'b0, s_ff} >= sq_t);
      rem2  = {rem_ff, nsh_ff[QW-1]};
      dv_ge = (rem2 >= {1'b0, len_ff});
      num   = (NW'(v_ff[k_ff][30:0]) << F) + NW'(len_ff >> 1);
      addend = ((md_ff == M_CR1 || md_ff == M_CR2) && j_ff == 2'd1) ?
               -ACCW'(prod_ff) : ACCW'(prod_ff);
      amag = '0;
      rq   = '0;
      fl   = '0;
      qs   = '0;
      mu   = '0;
      mdr  = '0;
      t32  = '0;

      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               for (int i = 0; i < 3; i++) begin
                  eye_in[i] = in_eye[i];
                  dir_in[i] = in_dir[i];
                  mu        = (in_up[i] < 0) ? -(W+1)'(in_up[i]) : (W+1)'(in_up[i]);
                  v_in[i]   = FW'($unsigned(mu));
                  sgn_in[i] = (in_up[i] < 0);
               end
               ph_in    = P_UP;
               state_in = S_FIT;
            end
         end
         S_FIT: begin
            if (|orv[FW-1:31]) begin
               for (int i = 0; i < 3; i++) v_in[i] = v_ff[i] >> 1;
            end else if (!orv[30] && !vz) begin
               for (int i = 0; i < 3; i++) v_in[i] = v_ff[i] << 1;
            end else if (ph_ff == P_UP) begin
               for (int i = 0; i < 3; i++) begin
                  t32       = $signed({1'b0, v_ff[i][30:0]});
                  upf_in[i] = sgn_ff[i] ? -t32 : t32;
                  mdr       = (dir_ff[i] < 0) ? -(W+2)'(dir_ff[i]) : (W+2)'(dir_ff[i]);
                  v_in[i]   = FW'($unsigned(mdr));
                  sgn_in[i] = (dir_ff[i] < 0);
               end
               ph_in = P_FWD;
            end else if (vz) begin
               // a zero-length vector normalizes to zero
               for (int i = 0; i < 3; i++) begin
                  if (ph_ff == P_FWD) fwd_in[i] = '0;
                  else rgt_in[i] = '0;
               end
               norm_done = 1'b1;
            end else begin
               md_in    = M_SQ;
               k_in     = 2'd0;
               j_in     = 2'd0;
               acc_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = opa * opb;
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in   = acc_ff + addend;
            state_in = S_MUL;
            case (md_ff)
               M_SQ: begin
                  if (k_ff == 2'd2) begin
                     s_in     = acc_in[63:0];
                     r_in     = '0;
                     bit_in   = 64'd1 << 62;
                     sc_in    = '0;
                     state_in = S_SQRT;
                  end else begin
                     k_in = k_ff + 2'd1;
                  end
               end
               M_CR1, M_CR2: begin
                  if (j_ff == 2'd0) begin
                     j_in = 2'd1;
                  end else begin
                     amag = (acc_in < 0) ? -acc_in : acc_in;
                     if (md_ff == M_CR1) begin
                        v_in[k_ff]   = amag[FW-1:0];
                        sgn_in[k_ff] = (acc_in < 0);
                     end else begin
                        rq          = (amag + HALF) >>> F;
                        tu_in[k_ff] = (acc_in < 0) ? -rq[F+2:0] : rq[F+2:0];
                     end
                     acc_in = '0;
                     j_in   = 2'd0;
                     if (k_ff == 2'd2) begin
                        k_in = 2'd0;
                        if (md_ff == M_CR1) begin
                           ph_in    = P_RGT;
                           state_in = S_FIT;
                        end else begin
                           md_in = M_DOT;
                        end
                     end else begin
                        k_in = k_ff + 2'd1;
                     end
                  end
               end
               default: begin
                  if (j_ff == 2'd2) begin
                     // round half up, negate, saturate
                     fl = -((acc_in + HALF) >>> F);
                     if (fl > MAXV) tr_in[k_ff] = MAXV[W-1:0];
                     else if (fl < MINV) tr_in[k_ff] = MINV[W-1:0];
                     else tr_in[k_ff] = fl[W-1:0];
                     acc_in = '0;
                     j_in   = 2'd0;
                     if (k_ff == 2'd2) state_in = S_DONE;
                     else k_in = k_ff + 2'd1;
                  end else begin
                     j_in = j_ff + 2'd1;
                  end
               end
            endcase
         end
         S_SQRT: begin
            if (sq_ge) begin
               s_in = s_ff - sq_t[63:0];
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            sc_in  = sc_ff + 5'd1;
            if (sc_ff == 5'd31) begin
               len_in   = r_in[31:0];
               k_in     = 2'd0;
               state_in = S_DIVI;
            end
         end
         S_DIVI: begin
            rem_in   = 32'(num >> QW);
            nsh_in   = num[QW-1:0];
            q_in     = '0;
            dc_in    = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = dv_ge ? 32'(rem2 - {1'b0, len_ff}) : rem2[31:0];
            nsh_in = nsh_ff << 1;
            q_in   = {q_ff[QW-2:0], dv_ge};
            dc_in  = dc_ff + DCW'(1);
            if (dc_ff == DCW'(QW - 1)) begin
               qs = $signed({2'b00, q_in});
               if (ph_ff == P_FWD) fwd_in[k_ff] = sgn_ff[k_ff] ? -qs : qs;
               else rgt_in[k_ff] = sgn_ff[k_ff] ? -qs : qs;
               if (k_ff == 2'd2) begin
                  norm_done = 1'b1;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = S_DIVI;
               end
            end
         end
         S_DONE: begin
            if (out_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (norm_done) begin
         md_in    = (ph_ff == P_FWD) ? M_CR1 : M_CR2;
         k_in     = 2'd0;
         j_in     = 2'd0;
         acc_in   = '0;
         state_in = S_MUL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ph_ff    <= P_UP;
         md_ff    <= M_SQ;
         k_ff     <= 2'd0;
         j_ff     <= 2'd0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         md_ff    <= md_in;
         k_ff     <= k_in;
         j_ff     <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      sgn_ff  <= sgn_in;
      eye_ff  <= eye_in;
      dir_ff  <= dir_in;
      upf_ff  <= upf_in;
      fwd_ff  <= fwd_in;
      rgt_ff  <= rgt_in;
      tu_ff   <= tu_in;
      tr_ff   <= tr_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      s_ff    <= s_in;
      r_ff    <= r_in;
      bit_ff  <= bit_in;
      sc_ff   <= sc_in;
      len_ff  <= len_in;
      rem_ff  <= rem_in;
      nsh_ff  <= nsh_in;
      q_ff    <= q_in;
      dc_ff   <= dc_in;
   end

endmodule

// ===== rtl/lvm_emit.sv =====
`timescale 1ns / 1ps
module lvm_emit #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        ld_valid,
   output logic                        ld_ready,
   input  logic signed [F+2:0]         rgt [3],
   input  logic signed [F+2:0]         tu [3],
   input  logic signed [F+2:0]         fwd [3],
   input  logic signed [W-1:0]         trans [3],
   output logic                        empty,
   input  logic                        pop,
   output lvm_pkg::col_idx_type        column_index,
   output logic signed [W-1:0]         row0,
   output logic signed [W-1:0]         row1,
   output logic signed [W-1:0]         row2,
   output logic signed [W-1:0]         row3,
   output logic                        last_column
);
   import lvm_pkg::*;

   localparam int SW = ((F + 3 > W) ? F + 3 : W) + 2;
   localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (W - 1)) - SW'(1);
   localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

   logic signed [F+2:0] rgt_ff [3];
   logic signed [F+2:0] tu_ff [3];
   logic signed [F+2:0] fwd_ff [3];
   logic signed [W-1:0] tr_ff [3];
   logic                busy_ff, busy_in;
   col_idx_type         col_ff, col_in;
   logic                take, last_pop;

   function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] x);
      if (x > MAXV) return $signed(MAXV[W-1:0]);
      if (x < MINV) return $signed(MINV[W-1:0]);
      return $signed(x[W-1:0]);
   endfunction

   assign empty       = !busy_ff;
   assign last_pop    = busy_ff && pop && (col_ff == COL_LAST);
   assign ld_ready    = !busy_ff || last_pop;
   assign take        = ld_valid && ld_ready;
   assign column_index = col_ff;
   assign last_column = (col_ff == COL_LAST);

   always_comb begin
      busy_in = busy_ff;
      col_in  = col_ff;
      if (take) begin
         busy_in = 1'b1;
         col_in  = '0;
      end else if (last_pop) begin
         busy_in = 1'b0;
      end else if (busy_ff && pop) begin
         col_in = col_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         col_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         col_ff  <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rgt_ff <= rgt;
         tu_ff  <= tu;
         fwd_ff <= fwd;
         tr_ff  <= trans;
      end
   end

   always_comb begin
      if (col_ff == COL_LAST) begin
         row0 = tr_ff[0];
         row1 = tr_ff[1];
         row2 = tr_ff[2];
         row3 = sat_w(SW'(1) <<< F);
      end else begin
         row0 = sat_w(SW'(rgt_ff[col_ff]));
         row1 = sat_w(SW'(tu_ff[col_ff]));
         row2 = sat_w(SW'(fwd_ff[col_ff]));
         row3 = '0;
      end
   end

endmodule

// ===== rtl/lookat_view_matrix_top.sv =====
`timescale 1ns / 1ps
// Right-handed look-at view matrix in signed fixed point. Each transaction on the
// request side carries eye, target and up hint; four transactions follow on the
// response side, columns 0 to 3 of the column-major view matrix, the last one
// flagged. A two-entry request queue takes new items while the back end works,
// and the response register bank drains while the next item is computed. The
// back end is one sequencer around a single shared multiplier, a one-bit-per-
// cycle square root and a one-bit-per-cycle divider; it takes the next item
// only after the last one is handed on, and its normalizing shift moves one
// bit at a time (at most 30 bits per vector, three vectors).
module lookat_view_matrix_top #(
   parameter int COORD_WIDTH = lvm_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = lvm_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [COORD_WIDTH-1:0] req_eye_x,
   input  logic signed [COORD_WIDTH-1:0] req_eye_y,
   input  logic signed [COORD_WIDTH-1:0] req_eye_z,
   input  logic signed [COORD_WIDTH-1:0] req_target_x,
   input  logic signed [COORD_WIDTH-1:0] req_target_y,
   input  logic signed [COORD_WIDTH-1:0] req_target_z,
   input  logic signed [COORD_WIDTH-1:0] req_up_x,
   input  logic signed [COORD_WIDTH-1:0] req_up_y,
   input  logic signed [COORD_WIDTH-1:0] req_up_z,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output lvm_pkg::col_idx_type          rsp_column_index,
   output logic signed [COORD_WIDTH-1:0] rsp_row0,
   output logic signed [COORD_WIDTH-1:0] rsp_row1,
   output logic signed [COORD_WIDTH-1:0] rsp_row2,
   output logic signed [COORD_WIDTH-1:0] rsp_row3,
   output logic                          rsp_last_column
);
   import lvm_pkg::*;

   localparam int W = COORD_WIDTH;
   localparam int F = FRAC_BITS;

   logic signed [W-1:0] eye_i [3];
   logic signed [W-1:0] tgt_i [3];
   logic signed [W-1:0] up_i [3];
   logic signed [W-1:0] q_eye [3];
   logic signed [W:0]   q_dir [3];
   logic signed [W-1:0] q_up [3];
   logic                q_valid, q_ready;
   logic                c_valid, c_ready;
   logic signed [F+2:0] c_rgt [3];
   logic signed [F+2:0] c_tu [3];
   logic signed [F+2:0] c_fwd [3];
   logic signed [W-1:0] c_tr [3];

   assign eye_i[0] = req_eye_x;
   assign eye_i[1] = req_eye_y;
   assign eye_i[2] = req_eye_z;
   assign tgt_i[0] = req_target_x;
   assign tgt_i[1] = req_target_y;
   assign tgt_i[2] = req_target_z;
   assign up_i[0]  = req_up_x;
   assign up_i[1]  = req_up_y;
   assign up_i[2]  = req_up_z;

   lvm_front #(.W(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .eye       (eye_i),
      .tgt       (tgt_i),
      .up        (up_i),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_eye   (q_eye),
      .out_dir   (q_dir),
      .out_up    (q_up)
   );

   lvm_core #(.W(W), .F(F)) u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_eye    (q_eye),
      .in_dir    (q_dir),
      .in_up     (q_up),
      .out_valid (c_valid),
      .out_ready (c_ready),
      .out_rgt   (c_rgt),
      .out_tu    (c_tu),
      .out_fwd   (c_fwd),
      .out_trans (c_tr)
   );

   lvm_emit #(.W(W), .F(F)) u_emit (
      .clock        (clock),
      .reset        (reset),
      .ld_valid     (c_valid),
      .ld_ready     (c_ready),
      .rgt          (c_rgt),
      .tu           (c_tu),
      .fwd          (c_fwd),
      .trans        (c_tr),
      .empty        (rsp_empty),
      .pop          (rsp_pop),
      .column_index (rsp_column_index),
      .row0         (rsp_row0),
      .row1         (rsp_row1),
      .row2         (rsp_row2),
      .row3         (rsp_row3),
      .last_column  (rsp_last_column)
   );

endmodule
